>>> hdl/fkc_pkg.sv
`default_nettype none
package fkc_pkg;

  localparam int unsigned OpW = 3;
  localparam int unsigned KindW = 3;
  localparam int unsigned FrameW = 21;
  localparam int unsigned HandleW = 32;
  localparam int unsigned StripW = 32;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ViewW = 4;
  localparam int unsigned DimW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 21;
  // distance score needs two more bits than a frame
  localparam int unsigned ScoreW = FrameW + 2;

  typedef enum logic [OpW-1:0] {
    OP_GET   = 3'd0,
    OP_PUT   = 3'd1,
    OP_INVAL = 3'd2,
    OP_CLEAR = 3'd3,
    OP_EVICT = 3'd4,
    OP_NOP   = 3'd7
  } op_e;

  typedef enum logic [KindW-1:0] {
    K_HIT      = 3'd0,
    K_MISS     = 3'd1,
    K_RELEASED = 3'd2,
    K_STORED   = 3'd3,
    K_FULL     = 3'd4,
    K_NONE     = 3'd5,
    K_DONE     = 3'd6
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CURRENT     = 3'd0,
    CFG_RANGE_START = 3'd1,
    CFG_RANGE_END   = 3'd2,
    CFG_GUARD_FIRST = 3'd3,
    CFG_GUARD_LAST  = 3'd4,
    CFG_GUARD_EN    = 3'd5
  } cfg_e;

  // one classified request passed from front to back
  typedef struct packed {
    logic [OpW-1:0]     opcode;
    logic               bypass;
    logic [StripW-1:0]  strip_id;
    logic [KeyW-1:0]    src_key;
    logic [ViewW-1:0]   view_number;
    logic [FrameW-1:0]  frame_position;
    logic               check_size;
    logic [HandleW-1:0] image_handle;
    logic [DimW-1:0]    width;
    logic [DimW-1:0]    height;
  } req_t;

  // one result item
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] handle;
    logic               last;
  } res_t;

  // eviction settings
  typedef struct packed {
    logic [FrameW-1:0] current_frame;
    logic [FrameW-1:0] range_start;
    logic [FrameW-1:0] range_end;
    logic [FrameW-1:0] guard_first;
    logic [FrameW-1:0] guard_last;
    logic              guard_enable;
  } cfg_t;

endpackage
`default_nettype wire

>>> hdl/fkc_queue.sv
`default_nettype none
module fkc_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  fkc_pkg::req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output fkc_pkg::req_t out_data_o
);
  import fkc_pkg::*;

  // two-entry request queue between front and back
  req_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end
endmodule
`default_nettype wire

>>> hdl/fkc_front.sv
`default_nettype none
module fkc_front (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire logic [fkc_pkg::OpW-1:0]     opcode_i,
  input  wire logic                        bypass_i,
  input  wire logic [fkc_pkg::StripW-1:0]  strip_id_i,
  input  wire logic [fkc_pkg::KeyW-1:0]    src_key_i,
  input  wire logic [fkc_pkg::ViewW-1:0]   view_number_i,
  input  wire logic [fkc_pkg::FrameW-1:0]  frame_position_i,
  input  wire logic                        check_size_i,
  input  wire logic [fkc_pkg::HandleW-1:0] image_handle_i,
  input  wire logic [fkc_pkg::DimW-1:0]    width_i,
  input  wire logic [fkc_pkg::DimW-1:0]    height_i,
  output logic      req_valid_o,
  input  wire logic req_ready_i,
  output fkc_pkg::req_t req_o
);
  import fkc_pkg::*;

  // input register; normalizes trivial requests to unused opcode
  logic req_valid_q;
  req_t req_q, req_d;

  assign ready_o     = !req_valid_q || req_ready_i;
  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

  always_comb begin
    req_d.opcode         = opcode_i;
    req_d.bypass         = bypass_i;
    req_d.strip_id       = strip_id_i;
    req_d.src_key        = src_key_i;
    req_d.view_number    = view_number_i;
    req_d.frame_position = frame_position_i;
    req_d.check_size     = check_size_i;
    req_d.image_handle   = image_handle_i;
    req_d.width          = width_i;
    req_d.height         = height_i;
    // bypassed put or null handle: answer done without touching the table
    if (opcode_i == OP_PUT && (bypass_i || image_handle_i == '0)) begin
      req_d.opcode = OP_NOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (ready_o) begin
      req_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_d;
    end
  end
endmodule
`default_nettype wire

>>> hdl/fkc_back.sv
`default_nettype none
module fkc_back #(
  parameter int unsigned TableDepth = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  fkc_pkg::cfg_t cfg_i,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  fkc_pkg::req_t req_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output fkc_pkg::res_t res_o
);
  import fkc_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(TableDepth - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_REL   = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;

  // valid bits in flops, payload in memories
  logic [TableDepth-1:0] valid_q;
  logic [StripW-1:0]  strip_mem  [TableDepth];
  logic [KeyW-1:0]    key_mem    [TableDepth];
  logic [ViewW-1:0]   view_mem   [TableDepth];
  logic [FrameW-1:0]  pos_mem    [TableDepth];
  logic [HandleW-1:0] handle_mem [TableDepth];
  logic [DimW-1:0]    width_mem  [TableDepth];
  logic [DimW-1:0]    height_mem [TableDepth];

  logic [2:0]      state_q, state_d;
  req_t            req_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] rd_addr;
  logic            rd_en;
  // registered read data
  logic [StripW-1:0]  rd_strip_q;
  logic [KeyW-1:0]    rd_key_q;
  logic [ViewW-1:0]   rd_view_q;
  logic [FrameW-1:0]  rd_pos_q;
  logic [HandleW-1:0] rd_handle_q;
  logic [DimW-1:0]    rd_width_q, rd_height_q;
  logic               rd_vld_q, rd_act_q;
  logic [IdxW-1:0]    rd_idx_q;

  logic              hit_q, hit_d, free_q, free_d, best_q, best_d, relstrip_q, relstrip_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, best_idx_q, best_idx_d;
  logic [ScoreW-1:0] best_score_q, best_score_d;
  logic [HandleW-1:0] hit_handle_q, hit_handle_d;
  logic [HandleW-1:0] best_handle_q;
  logic              size_bad_q, size_bad_d;

  logic       out_valid_q;
  res_t       out_q;
  logic       out_free;
  logic       emit;
  res_t       emit_res;
  logic       clr_en;
  logic [IdxW-1:0] clr_idx;
  logic       wr_en;
  logic [IdxW-1:0] wr_idx;

  assign out_free    = !out_valid_q || res_ready_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign req_ready_o = (state_q == S_IDLE);
  assign rd_addr     = idx_q[IdxW-1:0];
  // read data is held while the index waits on a stalled result
  assign rd_en       = (idx_d != idx_q);

  // memory read port, one entry per cycle while the index advances
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_strip_q  <= strip_mem[rd_addr];
      rd_key_q    <= key_mem[rd_addr];
      rd_view_q   <= view_mem[rd_addr];
      rd_pos_q    <= pos_mem[rd_addr];
      rd_handle_q <= handle_mem[rd_addr];
      rd_width_q  <= width_mem[rd_addr];
      rd_height_q <= height_mem[rd_addr];
      rd_vld_q    <= valid_q[rd_addr];
      rd_idx_q    <= rd_addr;
    end
  end

  // memory write port, on put
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      strip_mem[wr_idx]  <= req_q.strip_id;
      key_mem[wr_idx]    <= req_q.src_key;
      view_mem[wr_idx]   <= req_q.view_number;
      pos_mem[wr_idx]    <= req_q.frame_position;
      handle_mem[wr_idx] <= req_q.image_handle;
      width_mem[wr_idx]  <= req_q.width;
      height_mem[wr_idx] <= req_q.height;
    end
  end

  // eviction score of the entry just read
  logic signed [FrameW-1:0] head, fpos, gfirst, glast, rstart, rend;
  logic signed [FrameW:0]   diff;
  logic                     wraps, guarded;
  logic [ScoreW-1:0]        score;
  always_comb begin
    gfirst = signed'(cfg_i.guard_first);
    glast  = signed'(cfg_i.guard_last);
    rstart = signed'(cfg_i.range_start);
    rend   = signed'(cfg_i.range_end);
    fpos   = signed'(rd_pos_q);
    wraps  = cfg_i.guard_enable && (gfirst > glast);
    head   = wraps ? rstart : signed'(cfg_i.current_frame);
    if (!cfg_i.guard_enable) begin
      guarded = 1'b0;
    end else if (gfirst > glast) begin
      guarded = (fpos >= rstart && fpos <= glast) || (fpos >= gfirst && fpos <= rend);
    end else begin
      guarded = (fpos >= gfirst && fpos <= glast);
    end
    diff = {head[FrameW-1], head} - {fpos[FrameW-1], fpos};
    if (fpos < head) begin
      score = {diff[FrameW:0], 1'b0};
    end else begin
      score = ScoreW'(-diff);
    end
  end

  logic key_match, strip_match;
  assign strip_match = rd_vld_q && (rd_strip_q == req_q.strip_id);
  assign key_match   = strip_match && (rd_key_q == req_q.src_key) &&
                       (rd_view_q == req_q.view_number);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_handle_d = hit_handle_q;
    size_bad_d   = size_bad_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    best_score_d = best_score_q;
    relstrip_d   = relstrip_q;
    emit         = 1'b0;
    emit_res     = '{kind: K_DONE, handle: '0, last: 1'b0};
    clr_en       = 1'b0;
    clr_idx      = rd_idx_q;
    wr_en        = 1'b0;
    wr_idx       = hit_idx_q;
    case (state_q)
      S_IDLE: begin
        idx_d        = '0;
        hit_d        = 1'b0;
        free_d       = 1'b0;
        best_d       = 1'b0;
        best_score_d = '0;
        size_bad_d   = 1'b0;
        relstrip_d   = 1'b0;
        if (req_valid_i) begin
          state_d = S_SCAN;
        end
      end
      // first pass: lookup, free slot, eviction candidate
      S_SCAN: begin
        if (idx_q != LastIdx + 1'b1) begin
          idx_d = idx_q + 1'b1;
        end
        if (idx_q != '0) begin
          if (key_match && !hit_q) begin
            hit_d        = 1'b1;
            hit_idx_d    = rd_idx_q;
            hit_handle_d = rd_handle_q;
            size_bad_d   = (rd_width_q != req_q.width) || (rd_height_q != req_q.height);
          end
          if (!rd_vld_q && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (rd_vld_q && !guarded && score > best_score_q) begin
            best_d       = 1'b1;
            best_idx_d   = rd_idx_q;
            best_score_d = score;
          end
        end
        if (idx_q == LastIdx + 1'b1) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        idx_d = '0;
        case (req_q.opcode)
          OP_GET: begin
            if (req_q.bypass || !hit_q) begin
              state_d = S_FINAL;
            end else if (req_q.check_size && size_bad_q) begin
              relstrip_d = 1'b1;
              state_d    = S_READ;
            end else begin
              state_d = S_FINAL;
            end
          end
          OP_INVAL: begin
            relstrip_d = 1'b1;
            state_d    = S_READ;
          end
          OP_CLEAR: begin
            state_d = S_READ;
          end
          OP_PUT: begin
            if (hit_q) begin
              state_d = S_REL;
            end else begin
              state_d = S_FINAL;
            end
          end
          default: begin
            state_d = S_FINAL;
          end
        endcase
      end
      // put replacing an entry: old handle first
      S_REL: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_res = '{kind: K_RELEASED, handle: hit_handle_q, last: 1'b0};
          state_d  = S_FINAL;
        end
      end
      // release pass over the table, one entry a cycle unless a result is stalled
      S_READ: begin
        if (idx_q == '0) begin
          idx_d = idx_q + 1'b1;
        end else if (rd_vld_q && (!relstrip_q || strip_match)) begin
          if (out_free) begin
            emit     = 1'b1;
            emit_res = '{kind: K_RELEASED, handle: rd_handle_q, last: 1'b0};
            clr_en   = 1'b1;
            if (idx_q == LastIdx + 1'b1) begin
              state_d = S_FINAL;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end else if (idx_q == LastIdx + 1'b1) begin
          state_d = S_FINAL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (req_q.opcode)
            OP_GET: begin
              if (!req_q.bypass && hit_q && !relstrip_q) begin
                emit_res = '{kind: K_HIT, handle: hit_handle_q, last: 1'b1};
              end else begin
                emit_res = '{kind: K_MISS, handle: '0, last: 1'b1};
              end
            end
            OP_PUT: begin
              if (hit_q || free_q) begin
                wr_en    = 1'b1;
                wr_idx   = hit_q ? hit_idx_q : free_idx_q;
                emit_res = '{kind: K_STORED, handle: req_q.image_handle, last: 1'b1};
              end else begin
                emit_res = '{kind: K_FULL, handle: req_q.image_handle, last: 1'b1};
              end
            end
            OP_EVICT: begin
              if (best_q) begin
                clr_en   = 1'b1;
                clr_idx  = best_idx_q;
                emit_res = '{kind: K_RELEASED, handle: best_handle_q, last: 1'b1};
              end else begin
                emit_res = '{kind: K_NONE, handle: '0, last: 1'b1};
              end
            end
            default: begin
              emit_res = '{kind: K_DONE, handle: '0, last: 1'b1};
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // evicted handle is captured during the scan
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && idx_q != '0 && rd_vld_q && !guarded &&
        score > best_score_q) begin
      best_handle_q <= rd_handle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (clr_en) begin
        valid_q[clr_idx] <= 1'b0;
      end
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) begin
      req_q <= req_i;
    end
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    hit_handle_q <= hit_handle_d;
    size_bad_q   <= size_bad_d;
    free_q       <= free_d;
    free_idx_q   <= free_idx_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    best_score_q <= best_score_d;
    relstrip_q   <= relstrip_d;
    if (emit) begin
      out_q <= emit_res;
    end
  end
endmodule
`default_nettype wire

>>> hdl/frame_keyed_cache_with_distance_eviction.sv
`default_nettype none
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------
// request   | in_valid_i / in_ready_o    | opcode_i .. height_i
// result    | out_valid_o / out_ready_i  | kind_o, handle_out_o, last_o
// config    | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// the back end takes a transaction through an idle state, a lookup pass
// reading one slot a cycle, a decide state and a final state; a put that
// replaces an entry adds a release state before the final one.
// invalidate, clear and a failed size check add a release pass, which a
// stalled result can hold.
// reset clears valid bits at once, entry payload is not cleared.
// a stalled result holds the back end; a two-entry queue keeps the front accepting until it fills.
module frame_keyed_cache_with_distance_eviction #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic [fkc_pkg::OpW-1:0]     opcode_i,
  input  wire logic                        bypass_i,
  input  wire logic [fkc_pkg::StripW-1:0]  strip_id_i,
  input  wire logic [fkc_pkg::KeyW-1:0]    src_key_i,
  input  wire logic [fkc_pkg::ViewW-1:0]   view_number_i,
  input  wire logic [fkc_pkg::FrameW-1:0]  frame_position_i,
  input  wire logic                        check_size_i,
  input  wire logic [fkc_pkg::HandleW-1:0] image_handle_i,
  input  wire logic [fkc_pkg::DimW-1:0]    width_i,
  input  wire logic [fkc_pkg::DimW-1:0]    height_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [fkc_pkg::KindW-1:0]   kind_o,
  output logic [fkc_pkg::HandleW-1:0] handle_out_o,
  output logic                        last_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fkc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fkc_pkg::CfgDataW-1:0] cfg_data_i
);
  import fkc_pkg::*;

  cfg_t cfg_q;
  req_t f_req, q_req;
  logic f_valid, f_ready, q_valid, q_ready;
  res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_frame <= FrameW'(1);
      cfg_q.range_start   <= FrameW'(1);
      cfg_q.range_end     <= FrameW'(250);
      cfg_q.guard_first   <= '0;
      cfg_q.guard_last    <= '0;
      cfg_q.guard_enable  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CURRENT:     cfg_q.current_frame <= cfg_data_i;
        CFG_RANGE_START: cfg_q.range_start   <= cfg_data_i;
        CFG_RANGE_END:   cfg_q.range_end     <= cfg_data_i;
        CFG_GUARD_FIRST: cfg_q.guard_first   <= cfg_data_i;
        CFG_GUARD_LAST:  cfg_q.guard_last    <= cfg_data_i;
        CFG_GUARD_EN:    cfg_q.guard_enable  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  fkc_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .opcode_i, .bypass_i, .strip_id_i, .src_key_i, .view_number_i,
    .frame_position_i, .check_size_i, .image_handle_i, .width_i, .height_i,
    .req_valid_o(f_valid), .req_ready_i(f_ready), .req_o(f_req)
  );

  fkc_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_req),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_req)
  );

  fkc_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .req_valid_i(q_valid), .req_ready_o(q_ready), .req_i(q_req),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign kind_o       = res.kind;
  assign handle_out_o = res.handle;
  assign last_o       = res.last;
endmodule
`default_nettype wire
